// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset.
`define FKP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same, checked in the cycle after the antecedent.
`define FKP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  `FKP_ASSERT(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

// ===== sv/fkp_pkg.sv =====
`timescale 1ns / 1ps
package fkp_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned TagW   = 32;
  localparam int unsigned PosW   = 6;
  localparam int unsigned SplitW = 7;

  // command beat opcodes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_PART = 1'b1
  } op_e;

  typedef struct packed {
    logic load;       // append pair or flag overflow
    logic part;       // latch pivot, i = 0, j = fill
    logic emit_empty; // single empty beat
    logic rd_i;
    logic inc_i;
    logic cap_ki;
    logic dec_j;
    logic rd_j;
    logic cap_kj;
    logic wr_i;
    logic wr_j;
    logic rd_p;
    logic clr;        // empty store, clear overflow
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic i_lt_n;
    logic j_gt0;
    logic i_lt_j;
    logic l_before;   // stored word ranks before pivot
    logic r_before;   // pivot ranks before stored word
    logic p_last;
  } stat_t;

  // Descending float key, ascending tag on ties or NaN.
  function automatic logic ranks_before(logic [KeyW-1:0] ka, logic [TagW-1:0] ta,
                                        logic [KeyW-1:0] kb, logic [TagW-1:0] tb);
    logic        na;
    logic        nb;
    logic signed [KeyW-1:0] oa;
    logic signed [KeyW-1:0] ob;
    logic        r;
    na = (ka[30:23] == 8'hFF) && (ka[22:0] != 23'd0);
    nb = (kb[30:23] == 8'hFF) && (kb[22:0] != 23'd0);
    oa = ka[31] ? -$signed({1'b0, ka[30:0]}) : $signed({1'b0, ka[30:0]});
    ob = kb[31] ? -$signed({1'b0, kb[30:0]}) : $signed({1'b0, kb[30:0]});
    if (!na && !nb && (oa != ob)) begin
      r = (oa > ob);
    end else begin
      r = (ta < tb);
    end
    return r;
  endfunction

endpackage

// ===== sv/fkp_ctrl.sv =====
`timescale 1ns / 1ps
module fkp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           op_i,
  input  fkp_pkg::stat_t stat_i,
  output fkp_pkg::cmd_t  cmd_o,
  output logic           busy_o
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_L_RD  = 10'b0000000010,
    S_L_CMP = 10'b0000000100,
    S_R_DEC = 10'b0000001000,
    S_R_RD  = 10'b0000010000,
    S_R_CMP = 10'b0000100000,
    S_CHECK = 10'b0001000000,
    S_SWAP  = 10'b0010000000,
    S_E_RD  = 10'b0100000000,
    S_E_END = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (op_i == fkp_pkg::OP_LOAD) begin
            cmd_o.load = 1'b1;
          end else if (stat_i.empty) begin
            cmd_o.emit_empty = 1'b1;
            cmd_o.clr        = 1'b1;
          end else begin
            cmd_o.part = 1'b1;
            state_d    = S_L_RD;
          end
        end
      end
      S_L_RD: begin
        if (stat_i.i_lt_n) begin
          cmd_o.rd_i = 1'b1;
          state_d    = S_L_CMP;
        end else begin
          state_d = S_R_DEC;
        end
      end
      S_L_CMP: begin
        if (stat_i.l_before) begin
          cmd_o.inc_i = 1'b1;
          state_d     = S_L_RD;
        end else begin
          cmd_o.cap_ki = 1'b1;
          state_d      = S_R_DEC;
        end
      end
      S_R_DEC: begin
        cmd_o.dec_j = 1'b1;
        state_d     = S_R_RD;
      end
      S_R_RD: begin
        if (stat_i.j_gt0) begin
          cmd_o.rd_j = 1'b1;
          state_d    = S_R_CMP;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_R_CMP: begin
        if (stat_i.r_before) begin
          cmd_o.dec_j = 1'b1;
          state_d     = S_R_RD;
        end else begin
          cmd_o.cap_kj = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.i_lt_j) begin
          cmd_o.wr_i = 1'b1;
          state_d    = S_SWAP;
        end else begin
          state_d = S_E_RD;
        end
      end
      S_SWAP: begin
        cmd_o.wr_j  = 1'b1;
        cmd_o.inc_i = 1'b1;
        state_d     = S_L_RD;
      end
      S_E_RD: begin
        cmd_o.rd_p = 1'b1;
        if (stat_i.p_last) begin
          state_d = S_E_END;
        end
      end
      S_E_END: begin
        cmd_o.clr = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== sv/fkp_dp.sv =====
`timescale 1ns / 1ps
module fkp_dp #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fkp_pkg::cmd_t               cmd_i,
  input  logic [fkp_pkg::KeyW-1:0]    key_i,
  input  logic [fkp_pkg::TagW-1:0]    tag_i,
  output fkp_pkg::stat_t              stat_o,
  output logic                        valid_o,
  output logic [fkp_pkg::KeyW-1:0]    out_key_o,
  output logic [fkp_pkg::TagW-1:0]    out_tag_o,
  output logic [fkp_pkg::PosW-1:0]    position_o,
  output logic [fkp_pkg::SplitW-1:0]  split_o,
  output logic                        has_element_o,
  output logic                        dropped_o,
  output logic                        last_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = fkp_pkg::KeyW + fkp_pkg::TagW;

  logic [PW-1:0] mem [CAPACITY];
  logic [PW-1:0] rdata_q, ki_q, kj_q;
  logic [fkp_pkg::KeyW-1:0] pkey_q;
  logic [fkp_pkg::TagW-1:0] ptag_q;
  logic [CW-1:0] fill_q, i_q, j_q, p_q;
  logic [AW-1:0] pos_q;
  logic          ovf_q, stb_q, has_q, last_q, drop_q;
  logic          full;
  logic          wen, ren;
  logic [AW-1:0] waddr, raddr;
  logic [PW-1:0] wdata;

  assign full = (fill_q == CW'(CAPACITY));

  // single write port, single registered read port
  always_comb begin
    wen   = 1'b0;
    waddr = fill_q[AW-1:0];
    wdata = {key_i, tag_i};
    if (cmd_i.load && !full) begin
      wen = 1'b1;
    end else if (cmd_i.wr_i) begin
      wen   = 1'b1;
      waddr = i_q[AW-1:0];
      wdata = kj_q;
    end else if (cmd_i.wr_j) begin
      wen   = 1'b1;
      waddr = j_q[AW-1:0];
      wdata = ki_q;
    end
    ren   = cmd_i.rd_i | cmd_i.rd_j | cmd_i.rd_p;
    raddr = cmd_i.rd_j ? j_q[AW-1:0] : (cmd_i.rd_p ? p_q[AW-1:0] : i_q[AW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata_q <= mem[raddr];
    end
    if (cmd_i.cap_ki) ki_q <= rdata_q;
    if (cmd_i.cap_kj) kj_q <= rdata_q;
    if (cmd_i.part) begin
      pkey_q <= key_i;
      ptag_q <= tag_i;
    end
    if (cmd_i.rd_p) pos_q <= p_q[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
      i_q    <= '0;
      j_q    <= '0;
      p_q    <= '0;
      stb_q  <= 1'b0;
      has_q  <= 1'b0;
      last_q <= 1'b0;
      drop_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (full) ovf_q <= 1'b1;
        else      fill_q <= fill_q + CW'(1);
      end
      if (cmd_i.part) begin
        i_q <= '0;
        j_q <= fill_q;
        p_q <= '0;
      end
      if (cmd_i.inc_i) i_q <= i_q + CW'(1);
      if (cmd_i.dec_j) j_q <= j_q - CW'(1);
      if (cmd_i.rd_p)  p_q <= p_q + CW'(1);
      stb_q  <= cmd_i.rd_p | cmd_i.emit_empty;
      has_q  <= cmd_i.rd_p;
      last_q <= cmd_i.emit_empty | (cmd_i.rd_p & stat_o.p_last);
      if (cmd_i.rd_p | cmd_i.emit_empty) drop_q <= ovf_q;
      if (cmd_i.clr) begin
        fill_q <= '0;
        ovf_q  <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.empty    = (fill_q == '0);
    stat_o.i_lt_n   = (i_q < fill_q);
    stat_o.j_gt0    = (j_q != '0);
    stat_o.i_lt_j   = (i_q < j_q);
    stat_o.l_before = fkp_pkg::ranks_before(rdata_q[PW-1:fkp_pkg::TagW],
                                            rdata_q[fkp_pkg::TagW-1:0], pkey_q, ptag_q);
    stat_o.r_before = fkp_pkg::ranks_before(pkey_q, ptag_q, rdata_q[PW-1:fkp_pkg::TagW],
                                            rdata_q[fkp_pkg::TagW-1:0]);
    stat_o.p_last   = (p_q == fill_q - CW'(1));
  end

  assign valid_o       = stb_q;
  assign has_element_o = has_q;
  assign last_o        = last_q;
  assign dropped_o     = drop_q;
  assign out_key_o     = has_q ? rdata_q[PW-1:fkp_pkg::TagW] : '0;
  assign out_tag_o     = has_q ? rdata_q[fkp_pkg::TagW-1:0] : '0;
  assign position_o    = has_q ? fkp_pkg::PosW'(pos_q) : '0;
  assign split_o       = has_q ? fkp_pkg::SplitW'(i_q) : '0;

endmodule

// ===== sv/float_key_partition.sv =====
// Load: no result beat; busy stays low, so one load per cycle.
// Partition of n pairs: busy from the cycle after accept; a left scan reads and
//   compares to a bound, the right pointer steps in, a right scan does likewise,
//   then a check and a swap if i < j; then n beats, one per cycle, from the emit
//   sweep; busy stays high through the last beat. Empty store: one beat next cycle.
// Reset (rst_ni low, async): store empty, overflow flag clear; beats never stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module float_key_partition #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op_i,
  input  logic [fkp_pkg::KeyW-1:0]    key_i,
  input  logic [fkp_pkg::TagW-1:0]    tag_i,
  output logic                        valid_o,
  output logic [fkp_pkg::KeyW-1:0]    out_key_o,
  output logic [fkp_pkg::TagW-1:0]    out_tag_o,
  output logic [fkp_pkg::PosW-1:0]    position_o,
  output logic [fkp_pkg::SplitW-1:0]  split_o,
  output logic                        has_element_o,
  output logic                        dropped_o,
  output logic                        last_o
);

  fkp_pkg::cmd_t  cmd;
  fkp_pkg::stat_t stat;

  // sequencer: walks the two scan pointers, swaps, then the emit sweep
  fkp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .op_i   (op_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // pair store, pointers, comparator and result registers
  fkp_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .key_i        (key_i),
    .tag_i        (tag_i),
    .stat_o       (stat),
    .valid_o      (valid_o),
    .out_key_o    (out_key_o),
    .out_tag_o    (out_tag_o),
    .position_o   (position_o),
    .split_o      (split_o),
    .has_element_o(has_element_o),
    .dropped_o    (dropped_o),
    .last_o       (last_o)
  );

  // a beat only follows a busy cycle or an accepted command
  `FKP_ASSERT(a_beat_src, clk_i, rst_ni, valid_o |-> $past(busy || start), "stray beat")
  // the final beat of a non-empty run is not directly followed by another
  `FKP_ASSERT_NEXT(a_last_end, clk_i, rst_ni, valid_o && last_o && has_element_o, !valid_o, "beat after last")
  // a swap write never happens alongside a load
  `FKP_ASSERT(a_no_mix, clk_i, rst_ni, !(cmd.load && (cmd.wr_i || cmd.wr_j)), "write clash")

endmodule
